@@ design/lmqs_pkg.sv @@
// Shared types and constants for the local minimum query search block.
package lmqs_pkg;

    localparam int VAL_W   = 17;
    localparam int IDX_W   = 18;
    localparam int NB_W    = 18;
    localparam int EPOCH_W = 8;

    localparam logic [NB_W-1:0]    INF_VAL   = 18'h3FFFF;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [1:0] RK_QUERY  = 2'd0;
    localparam logic [1:0] RK_ANSWER = 2'd1;
    localparam logic [1:0] RK_NONE   = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_START,
        MODE_BISECT,
        MODE_SCAN
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR_RST,
        ST_WAIT,
        ST_CLEAR_WRAP,
        ST_BEGIN,
        ST_STEP,
        ST_LOOK,
        ST_DECIDE,
        ST_SPAN
    } state_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_ONE,
        POS_IDX,
        POS_CENTER
    } pos_sel_t;

    typedef struct packed {
        logic       clear;
        logic       load_start;
        logic       store_reply;
        logic       mem_rd;
        logic       apply_inf;
        logic       apply_hit;
        logic       span_init;
        logic       bisect_update;
        logic       scan_advance;
        logic       enter_span;
        logic       emit;
        logic [1:0] emit_kind;
        pos_sel_t   emit_pos;
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       epoch_wrap;
        logic       n_is_one;
        mode_t      mode;
        logic       scan_done;
        logic       in_range;
        logic       tag_hit;
        logic [1:0] phase;
        logic       start_less;
        logic       local_min;
        logic       out_free;
    } status_t;

endpackage

@@ design/lmqs_ctrl.sv @@
// Controller state machine for the local minimum query search block.
module lmqs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             kind,
    input  lmqs_pkg::status_t status,
    output logic             in_stall,
    output lmqs_pkg::cmd_t   cmd,
    output lmqs_pkg::state_t state
);

    lmqs_pkg::state_t state_reg;
    lmqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmqs_pkg::ST_CLEAR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmqs_pkg::ST_CLEAR_RST:
            begin
                if (status.clear_last)
                begin
                    state_next = lmqs_pkg::ST_WAIT;
                end
            end
            lmqs_pkg::ST_CLEAR_WRAP:
            begin
                if (status.clear_last)
                begin
                    state_next = lmqs_pkg::ST_BEGIN;
                end
            end
            lmqs_pkg::ST_WAIT:
            begin
                if (in_valid)
                begin
                    if (kind == lmqs_pkg::KIND_START)
                    begin
                        state_next = status.epoch_wrap ? lmqs_pkg::ST_CLEAR_WRAP
                                                       : lmqs_pkg::ST_BEGIN;
                    end
                    else if (status.mode != lmqs_pkg::MODE_IDLE)
                    begin
                        state_next = lmqs_pkg::ST_STEP;
                    end
                end
            end
            lmqs_pkg::ST_BEGIN:
            begin
                if (!status.n_is_one)
                begin
                    state_next = lmqs_pkg::ST_STEP;
                end
                else if (status.out_free)
                begin
                    state_next = lmqs_pkg::ST_WAIT;
                end
            end
            lmqs_pkg::ST_STEP:
            begin
                if (status.scan_done)
                begin
                    if (status.out_free)
                    begin
                        state_next = lmqs_pkg::ST_WAIT;
                    end
                end
                else if (!status.in_range)
                begin
                    state_next = lmqs_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = lmqs_pkg::ST_LOOK;
                end
            end
            lmqs_pkg::ST_LOOK:
            begin
                if (status.tag_hit)
                begin
                    state_next = lmqs_pkg::ST_DECIDE;
                end
                else if (status.out_free)
                begin
                    state_next = lmqs_pkg::ST_WAIT;
                end
            end
            lmqs_pkg::ST_DECIDE:
            begin
                if (status.mode == lmqs_pkg::MODE_START)
                begin
                    if (status.phase < 2'd2)
                    begin
                        state_next = lmqs_pkg::ST_STEP;
                    end
                    else if (status.start_less)
                    begin
                        if (status.out_free)
                        begin
                            state_next = lmqs_pkg::ST_WAIT;
                        end
                    end
                    else
                    begin
                        state_next = lmqs_pkg::ST_SPAN;
                    end
                end
                else
                begin
                    if (status.phase < 2'd3)
                    begin
                        state_next = lmqs_pkg::ST_STEP;
                    end
                    else if (status.local_min)
                    begin
                        if (status.out_free)
                        begin
                            state_next = lmqs_pkg::ST_WAIT;
                        end
                    end
                    else if (status.mode == lmqs_pkg::MODE_BISECT)
                    begin
                        state_next = lmqs_pkg::ST_SPAN;
                    end
                    else
                    begin
                        state_next = lmqs_pkg::ST_STEP;
                    end
                end
            end
            lmqs_pkg::ST_SPAN:
            begin
                state_next = lmqs_pkg::ST_STEP;
            end
            default:
            begin
                state_next = lmqs_pkg::ST_CLEAR_RST;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            lmqs_pkg::ST_CLEAR_RST,
            lmqs_pkg::ST_CLEAR_WRAP:
            begin
                cmd.clear = 1'b1;
            end
            lmqs_pkg::ST_WAIT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == lmqs_pkg::KIND_START)
                    begin
                        cmd.load_start = 1'b1;
                    end
                    else if (status.mode != lmqs_pkg::MODE_IDLE)
                    begin
                        cmd.store_reply = 1'b1;
                    end
                end
            end
            lmqs_pkg::ST_BEGIN:
            begin
                if (status.n_is_one && status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = lmqs_pkg::RK_ANSWER;
                    cmd.emit_pos  = lmqs_pkg::POS_ONE;
                end
            end
            lmqs_pkg::ST_STEP:
            begin
                if (status.scan_done)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = lmqs_pkg::RK_NONE;
                        cmd.emit_pos  = lmqs_pkg::POS_ZERO;
                    end
                end
                else if (!status.in_range)
                begin
                    cmd.apply_inf = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                end
            end
            lmqs_pkg::ST_LOOK:
            begin
                if (status.tag_hit)
                begin
                    cmd.apply_hit = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = lmqs_pkg::RK_QUERY;
                    cmd.emit_pos  = lmqs_pkg::POS_IDX;
                end
            end
            lmqs_pkg::ST_DECIDE:
            begin
                if (status.mode == lmqs_pkg::MODE_START)
                begin
                    if (status.phase >= 2'd2)
                    begin
                        if (status.start_less)
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = lmqs_pkg::RK_ANSWER;
                                cmd.emit_pos  = lmqs_pkg::POS_ONE;
                            end
                        end
                        else
                        begin
                            cmd.span_init = 1'b1;
                        end
                    end
                end
                else if (status.phase == 2'd3)
                begin
                    if (status.local_min)
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = lmqs_pkg::RK_ANSWER;
                            cmd.emit_pos  = lmqs_pkg::POS_CENTER;
                        end
                    end
                    else if (status.mode == lmqs_pkg::MODE_BISECT)
                    begin
                        cmd.bisect_update = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_advance = 1'b1;
                    end
                end
            end
            lmqs_pkg::ST_SPAN:
            begin
                cmd.enter_span = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/lmqs_datapath.sv @@
// Datapath: search bounds, neighbor values, tagged reply cache and result register.
module lmqs_datapath #(
    parameter int MAX_LEN = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lmqs_pkg::VAL_W-1:0]  value,
    input  lmqs_pkg::cmd_t              cmd,
    input  logic                        out_stall,
    output lmqs_pkg::status_t           status,
    output logic                        out_valid,
    output logic [1:0]                  result_kind,
    output logic [lmqs_pkg::VAL_W-1:0]  position
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int MEM_W  = lmqs_pkg::EPOCH_W + lmqs_pkg::VAL_W;
    localparam int IDX_W  = lmqs_pkg::IDX_W;
    localparam int NB_W   = lmqs_pkg::NB_W;
    localparam int VAL_W  = lmqs_pkg::VAL_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_LEN - 1);
    localparam logic [IDX_W-1:0]  ONE_IDX   = IDX_W'(1);
    localparam logic [IDX_W-1:0]  TWO_IDX   = IDX_W'(2);
    localparam logic [IDX_W:0]    THREE_EXT = (IDX_W + 1)'(3);

    logic [IDX_W-1:0]                 seq_len_reg, seq_len_next;
    logic [IDX_W-1:0]                 low_reg, low_next;
    logic [IDX_W-1:0]                 high_reg, high_next;
    logic [IDX_W-1:0]                 center_reg, center_next;
    logic [1:0]                       phase_reg, phase_next;
    logic [NB_W-1:0]                  nb_reg [3];
    logic [NB_W-1:0]                  nb_next [3];
    lmqs_pkg::mode_t                  mode_reg, mode_next;
    logic [lmqs_pkg::EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [ADDR_W-1:0]                clr_addr_reg, clr_addr_next;
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       result_kind_reg, result_kind_next;
    logic [VAL_W-1:0]                 position_reg, position_next;
    logic [MEM_W-1:0]                 rd_data_reg;

    logic [MEM_W-1:0]                 mem [MAX_LEN];

    logic [IDX_W-1:0]                 idx;
    logic [IDX_W-1:0]                 idx_m1;
    logic [ADDR_W-1:0]                rw_addr;
    logic                             in_range;
    logic [IDX_W-1:0]                 len_sat;
    logic [IDX_W:0]                   span_sum;
    logic                             go_bisect;
    logic [NB_W-1:0]                  apply_val;
    logic                             out_free;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [MEM_W-1:0]                 mem_wdata;
    logic                             falling;

    assign idx = (mode_reg == lmqs_pkg::MODE_START)
               ? IDX_W'(phase_reg) + ONE_IDX
               : center_reg - ONE_IDX + IDX_W'(phase_reg);
    assign idx_m1   = idx - ONE_IDX;
    assign rw_addr  = ADDR_W'(idx_m1);
    assign in_range = (idx != '0) && (idx <= seq_len_reg);

    assign len_sat  = (32'(value) > 32'(MAX_LEN)) ? IDX_W'(MAX_LEN) : IDX_W'(value);
    assign span_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign go_bisect = ({1'b0, low_reg} + THREE_EXT) < {1'b0, high_reg};

    assign apply_val = cmd.apply_inf ? lmqs_pkg::INF_VAL
                                     : {1'b0, rd_data_reg[VAL_W-1:0]};
    assign falling  = (nb_reg[0] > nb_reg[1]) && (nb_reg[1] > nb_reg[2]);
    assign out_free = !out_valid_reg || !out_stall;

    assign status.clear_last = (clr_addr_reg == LAST_ADDR);
    assign status.epoch_wrap = (epoch_reg == lmqs_pkg::EPOCH_MAX);
    assign status.n_is_one   = (seq_len_reg == ONE_IDX);
    assign status.mode       = mode_reg;
    assign status.scan_done  = (mode_reg == lmqs_pkg::MODE_SCAN) && (center_reg > high_reg);
    assign status.in_range   = in_range;
    assign status.tag_hit    = (rd_data_reg[MEM_W-1:VAL_W] == epoch_reg);
    assign status.phase      = phase_reg;
    assign status.start_less = (nb_reg[0] < nb_reg[1]);
    assign status.local_min  = (nb_reg[1] < nb_reg[0]) && (nb_reg[1] < nb_reg[2]);
    assign status.out_free   = out_free;

    always_comb
    begin
        seq_len_next     = seq_len_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        center_next      = center_reg;
        phase_next       = phase_reg;
        nb_next          = nb_reg;
        mode_next        = mode_reg;
        epoch_next       = epoch_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        result_kind_next = result_kind_reg;
        position_next    = position_reg;

        if (cmd.clear)
        begin
            clr_addr_next = status.clear_last ? '0 : clr_addr_reg + ADDR_W'(1);
        end

        if (cmd.load_start)
        begin
            seq_len_next = len_sat;
            low_next     = '0;
            high_next    = '0;
            center_next  = '0;
            phase_next   = '0;
            mode_next    = lmqs_pkg::MODE_START;
            epoch_next   = status.epoch_wrap ? lmqs_pkg::EPOCH_W'(1)
                                             : epoch_reg + lmqs_pkg::EPOCH_W'(1);
        end

        if (cmd.apply_inf || cmd.apply_hit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (phase_reg == 2'(i))
                begin
                    nb_next[i] = apply_val;
                end
            end
            phase_next = phase_reg + 2'd1;
        end

        if (cmd.span_init)
        begin
            low_next  = TWO_IDX;
            high_next = seq_len_reg;
        end

        if (cmd.bisect_update)
        begin
            if (falling)
            begin
                low_next = center_reg + ONE_IDX;
            end
            else
            begin
                high_next = center_reg - ONE_IDX;
            end
        end

        if (cmd.scan_advance)
        begin
            center_next = center_reg + ONE_IDX;
            phase_next  = '0;
        end

        if (cmd.enter_span)
        begin
            phase_next = '0;
            if (go_bisect)
            begin
                mode_next   = lmqs_pkg::MODE_BISECT;
                center_next = span_sum[IDX_W:1];
            end
            else
            begin
                mode_next   = lmqs_pkg::MODE_SCAN;
                center_next = low_reg;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            result_kind_next = cmd.emit_kind;
            unique case (cmd.emit_pos)
                lmqs_pkg::POS_ZERO:   position_next = '0;
                lmqs_pkg::POS_ONE:    position_next = VAL_W'(1);
                lmqs_pkg::POS_IDX:    position_next = idx[VAL_W-1:0];
                lmqs_pkg::POS_CENTER: position_next = center_reg[VAL_W-1:0];
                default:              position_next = '0;
            endcase
            if (cmd.emit_kind != lmqs_pkg::RK_QUERY)
            begin
                mode_next = lmqs_pkg::MODE_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            center_reg    <= '0;
            phase_reg     <= '0;
            nb_reg[0]     <= '0;
            nb_reg[1]     <= '0;
            nb_reg[2]     <= '0;
            mode_reg      <= lmqs_pkg::MODE_IDLE;
            epoch_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_len_reg   <= seq_len_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            center_reg    <= center_next;
            phase_reg     <= phase_next;
            nb_reg        <= nb_next;
            mode_reg      <= mode_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_kind_reg <= result_kind_next;
        position_reg    <= position_next;
    end

    // cache entry: {epoch tag, value}; tag 0 never matches a live epoch
    assign mem_we    = cmd.clear || (cmd.store_reply && in_range);
    assign mem_waddr = cmd.clear ? clr_addr_reg : rw_addr;
    assign mem_wdata = cmd.clear ? '0 : {epoch_reg, value};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rw_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign position    = position_reg;

endmodule

@@ design/local_minimum_query_search_top.sv @@
// Top level of the local minimum query search block: controller plus datapath.
//
//   channel | ports                      | word fields
//   --------+----------------------------+---------------------------
//   in      | in_valid, in_stall         | kind, value
//   out     | out_valid, out_stall       | result_kind, position
//
// A word is taken only while the controller waits; a start then passes the
// length-one check. Each position is then filled with the infinite value when
// out of range, taken from the cache on a tag hit, or sent out as a query on a
// miss, and each span update takes a step of its own; the cache read is registered.
// Reset runs a cache clearing pass over all MAX_LEN entries with in_stall high;
// a start that finds the 8-bit epoch tag at its top value runs it again first.
// A waiting result holds the controller until out_stall drops.
module local_minimum_query_search_top #(
    parameter int MAX_LEN = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [lmqs_pkg::VAL_W-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  result_kind,
    output logic [lmqs_pkg::VAL_W-1:0]  position
);

    lmqs_pkg::cmd_t    cmd;
    lmqs_pkg::status_t status;
    lmqs_pkg::state_t  state;

    lmqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd),
        .state    (state)
    );

    lmqs_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .result_kind (result_kind),
        .position    (position)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> in_stall)
        else $error("cache clearing while input open");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result loaded over a stalled word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == lmqs_pkg::KIND_START) |=> in_stall)
        else $error("start word did not make the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state == lmqs_pkg::ST_LOOK && $past(state) != lmqs_pkg::ST_LOOK)
            |-> $past(cmd.mem_rd))
        else $error("cache lookup without a read");

endmodule

@@ tb/tb.sv @@
// Testbench for local_minimum_query_search_top: directed table plus random searches.
`timescale 1ns / 100ps

module tb;

    localparam int VAL_W       = lmqs_pkg::VAL_W;
    localparam int NB_W        = lmqs_pkg::NB_W;
    localparam int LEN_MAX     = 65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 180;

    typedef struct packed {
        logic [1:0]       rk;
        logic [VAL_W-1:0] pos;
    } res_t;

    typedef struct packed {
        logic             k;
        logic [VAL_W-1:0] v;
        logic             typed;
        logic             has;
        logic [1:0]       rk;
        logic [VAL_W-1:0] pos;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             out_valid;
    logic             out_stall;
    logic [1:0]       result_kind;
    logic [VAL_W-1:0] position;

    // search predictor state
    int unsigned      srch_len;
    int unsigned      srch_lo;
    int unsigned      srch_hi;
    int unsigned      srch_mid;
    int unsigned      srch_cnt;
    logic [NB_W-1:0]  srch_nb [3];
    lmqs_pkg::mode_t  srch_mode;
    logic [VAL_W-1:0] srch_cache [int unsigned];

    res_t             pending_results [$];
    bit               used_vals [int unsigned];
    dir_row_t         dir_rows [24];

    int               idle_pct;
    int               stall_pct;
    bit               hold_off;
    int               errors;
    int unsigned      words_sent;
    int unsigned      results_seen;
    int unsigned      searches;
    int unsigned      phase_words;
    int unsigned      cycle_count;

    local_minimum_query_search_top #(
        .MAX_LEN(LEN_MAX)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .position    (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned probe_index();
        if (srch_mode == lmqs_pkg::MODE_START)
            return srch_cnt + 1;
        return srch_mid - 1 + srch_cnt;
    endfunction

    function automatic void pick_span();
        srch_cnt = 0;
        if (srch_lo + 3 < srch_hi)
        begin
            srch_mode = lmqs_pkg::MODE_BISECT;
            srch_mid  = (srch_lo + srch_hi) >> 1;
        end
        else
        begin
            srch_mode = lmqs_pkg::MODE_SCAN;
            srch_mid  = srch_lo;
        end
    endfunction

    function automatic void advance_search(output logic [1:0] rk,
                                           output logic [VAL_W-1:0] pos);
        int unsigned     idx;
        logic [NB_W-1:0] nv;
        logic [NB_W-1:0] a;
        logic [NB_W-1:0] b;
        logic [NB_W-1:0] c;
        while (1'b1)
        begin
            if (srch_mode == lmqs_pkg::MODE_SCAN && srch_mid > srch_hi)
            begin
                rk        = lmqs_pkg::RK_NONE;
                pos       = '0;
                srch_mode = lmqs_pkg::MODE_IDLE;
                return;
            end
            idx = probe_index();
            if (idx < 1 || idx > srch_len)
                nv = lmqs_pkg::INF_VAL;
            else if (srch_cache.exists(idx))
                nv = {1'b0, srch_cache[idx]};
            else
            begin
                rk  = lmqs_pkg::RK_QUERY;
                pos = idx[VAL_W-1:0];
                return;
            end
            srch_nb[srch_cnt] = nv;
            srch_cnt++;
            if (srch_mode == lmqs_pkg::MODE_START)
            begin
                if (srch_cnt < 2)
                    continue;
                if (srch_nb[0] < srch_nb[1])
                begin
                    rk        = lmqs_pkg::RK_ANSWER;
                    pos       = VAL_W'(1);
                    srch_mode = lmqs_pkg::MODE_IDLE;
                    return;
                end
                srch_lo = 2;
                srch_hi = srch_len;
                pick_span();
                continue;
            end
            if (srch_cnt < 3)
                continue;
            a = srch_nb[0];
            b = srch_nb[1];
            c = srch_nb[2];
            if (b < a && b < c)
            begin
                rk        = lmqs_pkg::RK_ANSWER;
                pos       = srch_mid[VAL_W-1:0];
                srch_mode = lmqs_pkg::MODE_IDLE;
                return;
            end
            if (srch_mode == lmqs_pkg::MODE_BISECT)
            begin
                if (a > b && b > c)
                    srch_lo = srch_mid + 1;
                else
                    srch_hi = srch_mid - 1;
                pick_span();
            end
            else
            begin
                srch_mid++;
                srch_cnt = 0;
            end
        end
    endfunction

    // returns 1 when the word causes a result
    function automatic bit search_step(input logic k, input logic [VAL_W-1:0] v,
                                       output logic [1:0] rk, output logic [VAL_W-1:0] pos);
        int unsigned n;
        int unsigned idx;
        rk  = lmqs_pkg::RK_QUERY;
        pos = '0;
        if (k == lmqs_pkg::KIND_START)
        begin
            n = (32'(v) > LEN_MAX) ? LEN_MAX : 32'(v);
            srch_cache.delete();
            srch_len = n;
            srch_lo  = 0;
            srch_hi  = 0;
            srch_mid = 0;
            srch_cnt = 0;
            if (n == 1)
            begin
                srch_mode = lmqs_pkg::MODE_IDLE;
                rk        = lmqs_pkg::RK_ANSWER;
                pos       = VAL_W'(1);
                return 1'b1;
            end
            srch_mode = lmqs_pkg::MODE_START;
            advance_search(rk, pos);
            return 1'b1;
        end
        if (srch_mode == lmqs_pkg::MODE_IDLE)
            return 1'b0;
        idx = probe_index();
        if (idx >= 1 && idx <= srch_len)
            srch_cache[idx] = v;
        advance_search(rk, pos);
        return 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] elem_value(input logic [VAL_W-1:0] idx, input int style);
        int unsigned t;
        if (style < 55)
        begin
            do
                t = $urandom_range(0, 131071);
            while (used_vals.exists(t));
            used_vals[t] = 1'b1;
        end
        else if (style < 70)
            t = $urandom_range(0, 3);
        else if (style < 85)
            t = 131071 - 32'(idx);
        else
            t = 32'(idx);
        return t[VAL_W-1:0];
    endfunction

    task automatic send_word(input logic k, input logic [VAL_W-1:0] v, input dir_row_t row,
                             output bit has, output logic [1:0] rk, output logic [VAL_W-1:0] pos);
        res_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        if (k == lmqs_pkg::KIND_START)
            searches++;
        has = search_step(k, v, rk, pos);
        if (row.typed)
        begin
            has = row.has;
            rk  = row.rk;
            pos = row.pos;
        end
        if (has)
        begin
            r.rk  = rk;
            r.pos = pos;
            pending_results = {pending_results, r};
        end
        @(negedge clk);
    endtask

    task automatic run_search();
        int unsigned      r;
        int unsigned      n;
        int               style;
        bit               has;
        logic [1:0]       rk;
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] v;
        dir_row_t         none_row;
        none_row = '0;
        used_vals.delete();
        r = $urandom_range(0, 99);
        if (r < 10)
            n = $urandom_range(65536, 131071);
        else if (r < 35)
            n = $urandom_range(11, 2000);
        else
            n = $urandom_range(0, 10);
        style = $urandom_range(0, 99);
        send_word(lmqs_pkg::KIND_START, n[VAL_W-1:0], none_row, has, rk, pos);
        phase_words++;
        while (has && rk == lmqs_pkg::RK_QUERY)
        begin
            // abandon now and then, so the next start lands on a busy search
            if ($urandom_range(0, 99) < 3)
                return;
            if ($urandom_range(0, 99) < 3)
            begin
                r = $urandom_range(0, 131071);
                v = r[VAL_W-1:0];
            end
            else
                v = elem_value(pos, style);
            send_word(lmqs_pkg::KIND_REPLY, v, none_row, has, rk, pos);
            phase_words++;
        end
        if ($urandom_range(0, 99) < 10)
        begin
            r = $urandom_range(0, 131071);
            send_word(lmqs_pkg::KIND_REPLY, r[VAL_W-1:0], none_row, has, rk, pos);
        end
    endtask

    // receiver
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: expected no result, got kind %0d position %0d",
                         $time, result_kind, position);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.rk)
                begin
                    errors++;
                    $display("%0t: result_kind expected %0d got %0d",
                             $time, want.rk, result_kind);
                end
                if (position !== want.pos)
                begin
                    errors++;
                    $display("%0t: position expected %0d got %0d",
                             $time, want.pos, position);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        bit               has;
        logic [1:0]       rk;
        logic [VAL_W-1:0] pos;
        int unsigned      r;
        dir_row_t         none_row;
        none_row     = '0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = lmqs_pkg::KIND_START;
        value        = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off     = 1'b0;
        errors       = 0;
        words_sent   = 0;
        results_seen = 0;
        searches     = 0;
        srch_mode    = lmqs_pkg::MODE_IDLE;
        srch_len     = 0;
        srch_lo      = 0;
        srch_hi      = 0;
        srch_mid     = 0;
        srch_cnt     = 0;
        srch_nb[0]   = '0;
        srch_nb[1]   = '0;
        srch_nb[2]   = '0;

        // kind, value, typed, has, rk, pos
        dir_rows = '{
            // reply while idle
            '{lmqs_pkg::KIND_REPLY, 17'h1FFFF, 1'b1, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_START, 17'd1,     1'b1, 1'b1, lmqs_pkg::RK_ANSWER, 17'd1},
            '{lmqs_pkg::KIND_START, 17'd0,     1'b1, 1'b1, lmqs_pkg::RK_NONE,   17'd0},
            // length saturates
            '{lmqs_pkg::KIND_START, 17'h1FFFF, 1'b1, 1'b1, lmqs_pkg::RK_QUERY,  17'd1},
            '{lmqs_pkg::KIND_REPLY, 17'd0,     1'b1, 1'b1, lmqs_pkg::RK_QUERY,  17'd2},
            '{lmqs_pkg::KIND_REPLY, 17'h1FFFF, 1'b1, 1'b1, lmqs_pkg::RK_ANSWER, 17'd1},
            '{lmqs_pkg::KIND_REPLY, 17'd5,     1'b1, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_START, 17'd2,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd10,    1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd5,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_START, 17'h10000, 1'b1, 1'b1, lmqs_pkg::RK_QUERY,  17'd1},
            '{lmqs_pkg::KIND_REPLY, 17'd100,   1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd50,    1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            // start while busy
            '{lmqs_pkg::KIND_START, 17'd3,     1'b1, 1'b1, lmqs_pkg::RK_QUERY,  17'd1},
            '{lmqs_pkg::KIND_REPLY, 17'd7,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd7,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            // no minimum in span
            '{lmqs_pkg::KIND_REPLY, 17'd9,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_START, 17'd10,    1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd5,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd3,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            // equal neighbors
            '{lmqs_pkg::KIND_REPLY, 17'd4,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd4,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd4,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0},
            '{lmqs_pkg::KIND_REPLY, 17'd8,     1'b0, 1'b0, lmqs_pkg::RK_QUERY,  17'd0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_pct  = 22;
        stall_pct = 22;
        foreach (dir_rows[i])
            send_word(dir_rows[i].k, dir_rows[i].v, dir_rows[i], has, rk, pos);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_off = 1'b1; end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
                run_search();
        end

        // enough starts to wrap the cache epoch tag
        repeat (260)
        begin
            r = $urandom_range(0, 3);
            send_word(lmqs_pkg::KIND_START, r[VAL_W-1:0], none_row, has, rk, pos);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d words over %0d searches, %0d results checked, %0d mismatches",
                 words_sent, searches, results_seen, errors);
        $display("Idle mixes: none, sender 62%%, receiver 62%%, both 22%%, one long receiver hold");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
